FILE: rtl/core/sha1bs_pkg.sv
// ----------------------------------------------------------------------------
// sha1bs_pkg
// Shared types and constants for the byte-stream SHA-1 engine.
// ----------------------------------------------------------------------------
package sha1bs_pkg;

  localparam logic [1:0] CMD_START  = 2'd0;
  localparam logic [1:0] CMD_DATA   = 2'd1;
  localparam logic [1:0] CMD_FINISH = 2'd2;

  localparam int NumWords   = 5;
  localparam int BlockBytes = 64;
  localparam int Rounds     = 80;
  localparam int LenPos     = 60;
  localparam int LastOneBlk = 55;

  localparam logic [31:0] IV0 = 32'h67452301;
  localparam logic [31:0] IV1 = 32'hEFCDAB89;
  localparam logic [31:0] IV2 = 32'h98BADCFE;
  localparam logic [31:0] IV3 = 32'h10325476;
  localparam logic [31:0] IV4 = 32'hC3D2E1F0;

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_MARK_BYTE = 8'h80;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] byte_value;
  } in_word_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last;
    logic        length_error;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_FOLD,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    PAD_MARK,
    PAD_ZERO,
    PAD_LEN
  } pad_sel_t;

  typedef enum logic [1:0] {
    PH_CH,
    PH_PAR1,
    PH_MAJ,
    PH_PAR2
  } phase_t;

  typedef struct packed {
    logic     start;
    logic     take;
    logic     pad_shift;
    pad_sel_t pad_sel;
    logic     round_en;
    phase_t   phase;
    logic     fold;
  } dp_cmd_t;

  typedef struct packed {
    logic [5:0] fill;
    logic       ovf;
  } dp_stat_t;

endpackage

FILE: rtl/core/sha1bs_dp.sv
// ----------------------------------------------------------------------------
// sha1bs_dp
// Datapath: 512-bit block/schedule shift line, working and chain registers,
// byte and bit counters, one SHA-1 round per cycle.
// ----------------------------------------------------------------------------
module sha1bs_dp
  import sha1bs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  dp_cmd_t     cmd,
  input  logic [7:0]  byte_in,
  input  logic [2:0]  rd_idx,
  output dp_stat_t    stat,
  output logic [31:0] digest_word,
  output logic        length_error
);

  logic [511:0] buf_r, buf_nxt;
  logic [31:0]  h_r   [NumWords];
  logic [31:0]  h_nxt [NumWords];
  logic [31:0]  a_r, b_r, c_r, d_r, e_r;
  logic [31:0]  a_nxt, b_nxt, c_nxt, d_nxt, e_nxt;
  logic [5:0]   fill_r, fill_nxt;
  logic [31:0]  bcnt_r, bcnt_nxt;
  logic         ovf_r, ovf_nxt;

  logic [7:0]   pad_byte;
  logic [7:0]   len_byte;
  logic [31:0]  w0, w_mix, w_new, f, k, t;

  always_comb begin
    case (fill_r[1:0])
      2'd0:    len_byte = bcnt_r[31:24];
      2'd1:    len_byte = bcnt_r[23:16];
      2'd2:    len_byte = bcnt_r[15:8];
      default: len_byte = bcnt_r[7:0];
    endcase
    case (cmd.pad_sel)
      PAD_MARK: pad_byte = PAD_MARK_BYTE;
      PAD_LEN:  pad_byte = len_byte;
      default:  pad_byte = 8'd0;
    endcase
  end

  // schedule: word k of the window sits at buf_r[511-32k -: 32]
  assign w0    = buf_r[511:480];
  assign w_mix = buf_r[95:64] ^ buf_r[255:224] ^ buf_r[447:416] ^ w0;
  assign w_new = {w_mix[30:0], w_mix[31]};

  always_comb begin
    case (cmd.phase)
      PH_CH:   begin f = (b_r & c_r) | (~b_r & d_r);              k = K0; end
      PH_PAR1: begin f = b_r ^ c_r ^ d_r;                         k = K1; end
      PH_MAJ:  begin f = (b_r & c_r) | (b_r & d_r) | (c_r & d_r); k = K2; end
      default: begin f = b_r ^ c_r ^ d_r;                         k = K3; end
    endcase
  end

  assign t = {a_r[26:0], a_r[31:27]} + f + e_r + k + w0;

  always_comb begin
    buf_nxt  = buf_r;
    h_nxt    = h_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    c_nxt    = c_r;
    d_nxt    = d_r;
    e_nxt    = e_r;
    fill_nxt = fill_r;
    bcnt_nxt = bcnt_r;
    ovf_nxt  = ovf_r;
    if (cmd.start) begin
      h_nxt[0] = IV0;
      h_nxt[1] = IV1;
      h_nxt[2] = IV2;
      h_nxt[3] = IV3;
      h_nxt[4] = IV4;
      a_nxt    = IV0;
      b_nxt    = IV1;
      c_nxt    = IV2;
      d_nxt    = IV3;
      e_nxt    = IV4;
      fill_nxt = '0;
      bcnt_nxt = '0;
      ovf_nxt  = 1'b0;
    end else if (cmd.take) begin
      if (!ovf_r) begin
        buf_nxt  = {buf_r[503:0], byte_in};
        fill_nxt = fill_r + 6'd1;
        bcnt_nxt = bcnt_r + 32'd8;
        if (bcnt_nxt == 32'd0) begin
          ovf_nxt = 1'b1;
        end
      end
    end else if (cmd.pad_shift) begin
      buf_nxt  = {buf_r[503:0], pad_byte};
      fill_nxt = fill_r + 6'd1;
    end else if (cmd.round_en) begin
      buf_nxt = {buf_r[479:0], w_new};
      e_nxt   = d_r;
      d_nxt   = c_r;
      c_nxt   = {b_r[1:0], b_r[31:2]};
      b_nxt   = a_r;
      a_nxt   = t;
    end else if (cmd.fold) begin
      h_nxt[0] = h_r[0] + a_r;
      h_nxt[1] = h_r[1] + b_r;
      h_nxt[2] = h_r[2] + c_r;
      h_nxt[3] = h_r[3] + d_r;
      h_nxt[4] = h_r[4] + e_r;
      a_nxt    = h_nxt[0];
      b_nxt    = h_nxt[1];
      c_nxt    = h_nxt[2];
      d_nxt    = h_nxt[3];
      e_nxt    = h_nxt[4];
    end
  end

  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_r[0]  <= IV0;
      h_r[1]  <= IV1;
      h_r[2]  <= IV2;
      h_r[3]  <= IV3;
      h_r[4]  <= IV4;
      a_r     <= IV0;
      b_r     <= IV1;
      c_r     <= IV2;
      d_r     <= IV3;
      e_r     <= IV4;
      fill_r  <= '0;
      bcnt_r  <= '0;
      ovf_r   <= 1'b0;
    end else begin
      h_r     <= h_nxt;
      a_r     <= a_nxt;
      b_r     <= b_nxt;
      c_r     <= c_nxt;
      d_r     <= d_nxt;
      e_r     <= e_nxt;
      fill_r  <= fill_nxt;
      bcnt_r  <= bcnt_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  always_comb begin
    case (rd_idx)
      3'd0:    digest_word = h_r[0];
      3'd1:    digest_word = h_r[1];
      3'd2:    digest_word = h_r[2];
      3'd3:    digest_word = h_r[3];
      default: digest_word = h_r[4];
    endcase
  end

  assign length_error = ovf_r;
  assign stat.fill    = fill_r;
  assign stat.ovf     = ovf_r;

endmodule

FILE: rtl/core/sha1bs_ctrl.sv
// ----------------------------------------------------------------------------
// sha1bs_ctrl
// Controller: command decode, padding sequence, round counter, digest output.
// ----------------------------------------------------------------------------
module sha1bs_ctrl
  import sha1bs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_cmd,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] word_idx,
  output logic       word_last,
  input  dp_stat_t   stat,
  output dp_cmd_t    dp_cmd
);

  localparam logic [6:0] LastRound = 7'(Rounds - 1);
  localparam logic [2:0] LastWord  = 3'(NumWords - 1);
  localparam logic [5:0] LastByte  = 6'(BlockBytes - 1);

  state_t     state_r, state_nxt;
  logic [6:0] round_r, round_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic       fin_r, fin_nxt;
  logic       final_r, final_nxt;
  logic       first_r, first_nxt;
  logic       accept;

  assign accept = in_valid && (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    round_nxt = round_r;
    idx_nxt   = idx_r;
    fin_nxt   = fin_r;
    final_nxt = final_r;
    first_nxt = first_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_cmd == CMD_DATA) begin
            if (!stat.ovf && stat.fill == LastByte) begin
              state_nxt = ST_ROUND;
              round_nxt = '0;
            end
          end else if (in_cmd == CMD_FINISH) begin
            state_nxt = ST_PAD;
            fin_nxt   = 1'b1;
            first_nxt = 1'b1;
            final_nxt = (stat.fill <= 6'(LastOneBlk));
          end
        end
      end
      ST_PAD: begin
        first_nxt = 1'b0;
        if (stat.fill == LastByte) begin
          state_nxt = ST_ROUND;
          round_nxt = '0;
        end
      end
      ST_ROUND: begin
        round_nxt = round_r + 7'd1;
        if (round_r == LastRound) begin
          state_nxt = ST_FOLD;
        end
      end
      ST_FOLD: begin
        if (!fin_r) begin
          state_nxt = ST_IDLE;
        end else if (final_r) begin
          state_nxt = ST_EMIT;
          idx_nxt   = '0;
        end else begin
          state_nxt = ST_PAD;
          final_nxt = 1'b1;
          first_nxt = 1'b0;
        end
      end
      ST_EMIT: begin
        if (out_ready) begin
          if (idx_r == LastWord) begin
            state_nxt = ST_IDLE;
            fin_nxt   = 1'b0;
          end else begin
            idx_nxt = idx_r + 3'd1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready         = (state_r == ST_IDLE);
    out_valid        = (state_r == ST_EMIT);
    word_idx         = idx_r;
    word_last        = (idx_r == LastWord);
    dp_cmd.start     = accept && (in_cmd == CMD_START);
    dp_cmd.take      = accept && (in_cmd == CMD_DATA);
    dp_cmd.pad_shift = (state_r == ST_PAD);
    dp_cmd.round_en  = (state_r == ST_ROUND);
    dp_cmd.fold      = (state_r == ST_FOLD);
    if (first_r) begin
      dp_cmd.pad_sel = PAD_MARK;
    end else if (final_r && stat.fill >= 6'(LenPos)) begin
      dp_cmd.pad_sel = PAD_LEN;
    end else begin
      dp_cmd.pad_sel = PAD_ZERO;
    end
    if (round_r < 7'd20) begin
      dp_cmd.phase = PH_CH;
    end else if (round_r < 7'd40) begin
      dp_cmd.phase = PH_PAR1;
    end else if (round_r < 7'd60) begin
      dp_cmd.phase = PH_MAJ;
    end else begin
      dp_cmd.phase = PH_PAR2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      round_r <= '0;
      idx_r   <= '0;
      fin_r   <= 1'b0;
      final_r <= 1'b0;
      first_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      round_r <= round_nxt;
      idx_r   <= idx_nxt;
      fin_r   <= fin_nxt;
      final_r <= final_nxt;
      first_r <= first_nxt;
    end
  end

endmodule

FILE: rtl/core/sha1_byte_stream_hash_top.sv
// ----------------------------------------------------------------------------
// sha1_byte_stream_hash_top
// Byte-serial SHA-1 engine: start / data byte / finish words in, five
// digest words out.
//
//   channel  ports                        word
//   input    in_valid in_ready in_data    cmd, byte_value
//   result   out_valid out_ready out_data digest_word, word_index, last,
//                                         length_error
//
// A data byte is taken while idle; the byte that fills a block is then
// compressed (80 rounds on one round unit, then the chain add).
// Finish: one padding byte per cycle up to the block end, then compression;
// a second padded block when 56 or more bytes are held, then five words.
// Reset is synchronous and loads the initial chain value; no clearing pass.
// in_ready is low while padding, while a block is compressed and while the
// digest is sent; a stalled result word holds until out_ready.
// ----------------------------------------------------------------------------
module sha1_byte_stream_hash_top
  import sha1bs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  dp_cmd_t    dp_cmd;
  dp_stat_t   dp_stat;
  logic [2:0] word_idx;
  logic       word_last;
  logic [31:0] digest_word;
  logic       length_error;

  sha1bs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_cmd    (in_data.cmd),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .word_idx  (word_idx),
    .word_last (word_last),
    .stat      (dp_stat),
    .dp_cmd    (dp_cmd)
  );

  sha1bs_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (dp_cmd),
    .byte_in      (in_data.byte_value),
    .rd_idx       (word_idx),
    .stat         (dp_stat),
    .digest_word  (digest_word),
    .length_error (length_error)
  );

  assign out_data.digest_word  = digest_word;
  assign out_data.word_index   = word_idx;
  assign out_data.last         = word_last;
  assign out_data.length_error = length_error;

`ifndef SYNTH
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input taken while digest is sent");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_data.last) |=> !out_valid)
    else $error("digest words continue after last");

  a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_data.last) |=>
      (out_valid && out_data.word_index == 3'($past(out_data.word_index) + 3'd1)))
    else $error("digest word index did not advance");

  a_block_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_data.cmd == CMD_DATA && !dp_stat.ovf &&
     dp_stat.fill == 6'd63) |=> !in_ready)
    else $error("full block not compressed");
`endif

endmodule
